FILE: rtl/core/quantized_mac_requantize_assert.svh
// Assertion macros used by the quantized MAC controller.
`ifndef QUANTIZED_MAC_REQUANTIZE_ASSERT_SVH
`define QUANTIZED_MAC_REQUANTIZE_ASSERT_SVH

// Property that must hold at every clock edge outside of reset.
`define QMR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("qmr assertion failed");

// When the trigger holds, the consequence must hold in the following cycle.
`define QMR_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("qmr sequencing assertion failed");

`endif

FILE: rtl/core/qmr_pkg.sv
package qmr_pkg;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned RQ_W      = 64;
  localparam int unsigned RQ_SHIFT  = 15;
  localparam int unsigned ACC_SHIFT = 16;

  localparam logic signed [RQ_W-1:0] ROUND_HALF = 64'sd16384;
  localparam logic signed [15:0]     OUT_MAX    = 16'sh7fff;
  localparam logic signed [15:0]     OUT_MIN    = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_RQ_MUL,
    ST_RQ_SAT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic accumulate;
    logic rq_mul;
    logic rq_out;
  } qmr_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic last;
    logic out_stall;
  } qmr_sts_t;

endpackage

FILE: rtl/core/qmr_ctrl.sv
`include "quantized_mac_requantize_assert.svh"

module qmr_ctrl
  import qmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  qmr_sts_t sts,
  output qmr_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = sts.last ? ST_RQ_MUL : ST_IDLE;
      end
      ST_RQ_MUL: begin
        state_next = ST_RQ_SAT;
      end
      ST_RQ_SAT: begin
        if (!sts.out_stall) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
      end
      ST_RQ_MUL: begin
        cmd.rq_mul = 1'b1;
      end
      ST_RQ_SAT: begin
        cmd.rq_out = !sts.out_stall;
      end
    endcase
  end

  // At most one datapath command is issued in any cycle.
  `QMR_ASSERT(a_cmd_onehot, $onehot0(cmd))
  // A captured term is always accumulated in the following cycle.
  `QMR_ASSERT_NEXT(a_capture_then_acc, cmd.capture, cmd.accumulate)
  // The final term of a sum is always followed by the rescaling multiply.
  `QMR_ASSERT_NEXT(a_last_then_mul, cmd.accumulate && sts.last, cmd.rq_mul)
  // A new result never overwrites one the receiver has not yet taken.
  `QMR_ASSERT(a_no_overwrite, cmd.rq_out |-> !sts.out_stall)

endmodule

FILE: rtl/core/qmr_dp.sv
module qmr_dp
  import qmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  qmr_cmd_t           cmd,
  output qmr_sts_t           sts,
  input  logic signed [15:0] weight,
  input  logic signed [15:0] activation,
  input  logic signed [31:0] bias,
  input  logic signed [31:0] multiplier,
  input  logic               first_term,
  input  logic               last_term,
  input  logic               cfg_wen,
  input  logic               cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]       bias_r;
  logic signed [31:0]       mult_r;
  logic                     first_r;
  logic                     last_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       held_mult;
  logic signed [RQ_W-1:0]   rq_prod;
  logic                     relu_en;

  logic signed [ACC_W-1:0]          acc_base;
  logic signed [RQ_W-1:0]           rq_sum;
  logic [RQ_W-RQ_SHIFT-1:0]         rq_val;
  logic                             sat_hi;
  logic                             sat_lo;
  logic signed [15:0]               res_next;

  // Operand capture: the 16x16 product is registered on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r  <= weight * activation;
      bias_r  <= bias;
      mult_r  <= multiplier;
      first_r <= first_term;
      last_r  <= last_term;
    end
  end

  assign acc_base = first_r ? {{(ACC_W-32){bias_r[31]}}, bias_r} : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held_mult <= '0;
    end else if (cmd.accumulate) begin
      acc <= acc_base + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      if (first_r) begin
        held_mult <= mult_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rq_mul) begin
      rq_prod <= $signed(acc[ACC_W-1:ACC_SHIFT]) * held_mult;
    end
  end

  // Round half up, floor shift, then rectify and saturate to int16.
  always_comb begin
    rq_sum = rq_prod + ROUND_HALF;
    rq_val = rq_sum[RQ_W-1:RQ_SHIFT];
    sat_hi = !rq_val[RQ_W-RQ_SHIFT-1] && (rq_val[RQ_W-RQ_SHIFT-2:15] != '0);
    sat_lo = rq_val[RQ_W-RQ_SHIFT-1] && (rq_val[RQ_W-RQ_SHIFT-2:15] != '1);
    priority if (relu_en && rq_val[RQ_W-RQ_SHIFT-1]) begin
      res_next = '0;
    end else if (sat_hi) begin
      res_next = OUT_MAX;
    end else if (sat_lo) begin
      res_next = OUT_MIN;
    end else begin
      res_next = $signed(rq_val[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rq_out) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rq_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relu_en <= 1'b0;
    end else if (cfg_wen) begin
      relu_en <= cfg_wdata;
    end
  end

  assign sts.last      = last_r;
  assign sts.out_stall = out_valid && !out_ready;

endmodule

FILE: rtl/core/quantized_mac_requantize.sv
// Quantized multiply-accumulate with int16 requantization.
// Input channel (in_valid/in_ready): one beat carries one weight/activation
// term. A beat with first_term set loads the accumulator with bias and
// captures multiplier; a beat with last_term set closes the sum.
// Output channel (out_valid/out_ready): one beat per closed sum, carrying
// ((acc >> 16) * multiplier + 2^14) >> 15, clamped at zero when ReLU is
// enabled and saturated to int16.
// Sequence: a term that does not close a sum passes through capture with
// the 16x16 multiply, then the 48-bit accumulate; a closing term further
// passes through the 32x32 rescale multiply and the rounding and
// saturation stage. The sequencing controller sets this order, and a new
// term is accepted only once the previous one is through. The result
// beat becomes valid when the saturation stage registers it.
// A finished result sits in the output register; the next terms are still
// accepted while it waits. Only when a second result is ready before the
// first is taken does the block hold in its saturation stage.
// Reset (rst, synchronous) clears the accumulator, the held multiplier,
// the ReLU enable and the output valid. The user must write relu_enable
// via cfg_wen/cfg_wdata only while the block is idle; it does not enforce this.
module quantized_mac_requantize
  import qmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] weight,
  input  logic signed [15:0] activation,
  input  logic signed [31:0] bias,
  input  logic signed [31:0] multiplier,
  input  logic               first_term,
  input  logic               last_term,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result,
  input  logic               cfg_wen,
  input  logic               cfg_wdata
);

  // Command and status bundles between the sequencer and the datapath.
  qmr_cmd_t cmd;
  qmr_sts_t sts;

  // The controller walks each term through capture and accumulate, and a
  // closing term further through rescale and saturate.
  qmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the accumulator, the multiplier, the ReLU enable and
  // the output register.
  qmr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .weight     (weight),
    .activation (activation),
    .bias       (bias),
    .multiplier (multiplier),
    .first_term (first_term),
    .last_term  (last_term),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import qmr_pkg::*;

  // Number of input beats the run aims for, and the point after which both
  // sides stop idling so the tail of the run goes at full rate.
  localparam int unsigned TERM_GOAL    = 1100;
  localparam int unsigned QUIET_TAIL   = 150;
  // Cycles in which neither channel moves a beat before the run is declared hung.
  localparam int unsigned HANG_LIMIT   = 1000;
  // Quiet cycles after the last predicted output comes back, enough for the
  // block to finish any term that produced no output and be idle.
  localparam int unsigned DRAIN_CYCLES = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] weight = '0;
  logic signed [15:0] activation = '0;
  logic signed [31:0] bias = '0;
  logic signed [31:0] multiplier = '0;
  logic               first_term = 1'b0;
  logic               last_term = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic signed [15:0] result;
  logic               cfg_wen = 1'b0;
  logic               cfg_wdata = 1'b0;

  quantized_mac_requantize uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .weight     (weight),
    .activation (activation),
    .bias       (bias),
    .multiplier (multiplier),
    .first_term (first_term),
    .last_term  (last_term),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the block's state: the 48-bit running sum, the multiplier
  // captured by the last first term, and the ReLU enable.
  logic signed [ACC_W-1:0] sum_state = '0;
  logic signed [31:0]      scale_state = '0;
  bit                      relu_state = 1'b0;

  // Requantized outputs predicted for closed sums, oldest first.
  logic signed [15:0] requant_results[$];

  int unsigned terms_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;     // chance in percent that a side starts an idle burst
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // Rescale a closed sum: floor shifts on both steps, rounding by adding half
  // an LSB of the second shift, then the optional clamp at zero and the
  // saturation of the full 64-bit value to int16.
  function automatic logic signed [15:0] requantize(input logic signed [ACC_W-1:0] sum,
                                                    input logic signed [31:0] scale,
                                                    input bit relu);
    longint top;
    longint scaled;
    longint v;
    top    = longint'(sum >>> ACC_SHIFT);
    scaled = top * longint'(scale) + longint'(ROUND_HALF);
    v      = scaled >>> RQ_SHIFT;
    if (relu && v < 0) begin
      v = 0;
    end
    if (v > longint'(OUT_MAX)) begin
      v = longint'(OUT_MAX);
    end else if (v < longint'(OUT_MIN)) begin
      v = longint'(OUT_MIN);
    end
    return v[15:0];
  endfunction

  // Apply one accepted term to the predicted state. A first term reloads the
  // sum from its bias and captures its multiplier before the product is added;
  // a last term queues the requantized value but leaves the sum as it is.
  task automatic accumulate_term(input logic signed [15:0] w, input logic signed [15:0] a,
                                 input logic signed [31:0] b, input logic signed [31:0] m,
                                 input bit f, input bit l);
    logic signed [31:0] prod;
    prod = w * a;
    if (f) begin
      sum_state   = ACC_W'(b);
      scale_state = m;
    end
    sum_state = sum_state + ACC_W'(prod);
    if (l) begin
      requant_results.push_back(requantize(sum_state, scale_state, relu_state));
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Present one term and hold it until the block takes it. The input side may
  // first drop valid for a short burst. Valid is lowered in this task only inside a
  // burst, so a term that follows directly keeps valid high without a glitch.
  task automatic send_term(input logic signed [15:0] w, input logic signed [15:0] a,
                           input logic signed [31:0] b, input logic signed [31:0] m,
                           input bit f, input bit l);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    weight     <= w;
    activation <= a;
    bias       <= b;
    multiplier <= m;
    first_term <= f;
    last_term  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_term(w, a, b, m, f, l);
    terms_sent++;
  endtask

  // Let every predicted output come back, then give the block time to finish
  // any term that produced no output.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (requant_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_relu(input bit enable);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    relu_state = enable;
  endtask

  // Operand generators lean toward the extremes and toward small values, since
  // only small multipliers give outputs that do not saturate.
  function automatic logic signed [15:0] rand_operand();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = '0;
      3, 4, 5: begin
        v = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_bias();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = '0;
      3, 4, 5, 6: begin
        v = 32'($urandom_range(0, 24'hffffff));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 32'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_scale();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = '0;
      3, 4, 5, 6: begin
        v = 32'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        v = 32'($urandom_range(0, 20'hfffff));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 32'($urandom);
    endcase
    return v;
  endfunction

  // One complete sum: a first term with its bias and multiplier, then middle
  // terms whose bias and multiplier fields carry junk the block must ignore,
  // then the closing term. Full-scale sums use the most negative operands.
  task automatic send_sum(input int unsigned terms, input bit full_scale);
    logic signed [31:0] b;
    logic signed [31:0] m;
    logic signed [15:0] w;
    logic signed [15:0] a;
    b = rand_bias();
    m = rand_scale();
    for (int unsigned i = 0; i < terms; i++) begin
      w = full_scale ? 16'sh8000 : rand_operand();
      a = full_scale ? 16'sh8000 : rand_operand();
      if (i == 0) begin
        send_term(w, a, b, m, 1'b1, i == terms - 1);
      end else begin
        send_term(w, a, 32'($urandom), 32'($urandom), 1'b0, i == terms - 1);
      end
    end
  endtask

  // Corner operands closed in a single term, which saturate both ways.
  task automatic test_extremes();
    send_term(16'sh8000, 16'sh8000, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1);
    send_term(16'sh7fff, 16'sh8000, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1);
    send_term(16'sh8000, 16'sh7fff, 32'sh80000000, 32'sh80000000, 1'b1, 1'b1);
    send_term(16'sh0000, 16'sh0000, 32'sh00000000, 32'sh00000000, 1'b1, 1'b1);
  endtask

  // Values right at the rounding boundary, for a positive and a negative top
  // half of the sum, to show the shifts floor rather than truncate.
  task automatic test_rounding();
    send_term(16'sh0000, 16'sh1234, 32'sh00010000, 32'sd16384, 1'b1, 1'b1);
    send_term(16'sh0000, 16'sh1234, 32'sh00010000, 32'sd16383, 1'b1, 1'b1);
    send_term(16'sh0000, 16'sh1234, -32'sh00010000, 32'sd16384, 1'b1, 1'b1);
    send_term(16'sh0000, 16'sh1234, -32'sh00010000, 32'sd16385, 1'b1, 1'b1);
  endtask

  // Sums of several terms, one of them near full scale with a wide product
  // that must saturate instead of wrapping to a small int16.
  task automatic test_multi_term();
    send_term(16'sd100, -16'sd200, 32'sd5000, 32'sd3, 1'b1, 1'b0);
    send_term(16'sd300, 16'sd400, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0);
    send_term(-16'sd500, 16'sd600, 32'sh80000000, 32'sh80000000, 1'b0, 1'b1);
    send_sum(5, 1'b1);
  endtask

  // Terms without a first term build on whatever the sum holds, including
  // what a closed sum left behind, and keep the captured multiplier.
  task automatic test_no_first_term();
    send_term(16'sd1000, 16'sd1000, 32'sd0, 32'sd1, 1'b0, 1'b1);
    send_term(16'sd2000, -16'sd3000, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0);
    send_term(16'sh7fff, 16'sh7fff, 32'sh80000000, 32'sh80000000, 1'b0, 1'b1);
    send_term(16'sd1, 16'sd1, 32'sd12345, 32'sd9, 1'b0, 1'b1);
  endtask

  // With ReLU on, a negative value clamps to zero; a positive one passes, though the one driven here rounds to zero.
  task automatic test_relu();
    set_relu(1'b1);
    send_term(-16'sd4000, 16'sd4000, 32'sd0, 32'sd20000, 1'b1, 1'b1);
    send_term(16'sd4000, 16'sd4000, 32'sd0, 32'sd20, 1'b1, 1'b1);
    send_term(16'sh8000, 16'sh7fff, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1);
    set_relu(1'b0);
  endtask

  // Mostly well-formed sums of random length and content, with some runs that
  // carry on from the previous sum and some single beats with random flags.
  // The idle level changes now and then, and ReLU is flipped between phases.
  task automatic test_random();
    int unsigned pick;
    int unsigned terms;
    while (terms_sent < TERM_GOAL) begin
      if (terms_sent + QUIET_TAIL >= TERM_GOAL) begin
        idle_pct = 0;
      end else begin
        if ($urandom_range(0, 29) == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
          endcase
        end
        if ($urandom_range(0, 59) == 0) begin
          set_relu(!relu_state);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        terms = $urandom_range(0, 99);
        if (terms < 85) begin
          send_sum($urandom_range(1, 6), 1'b0);
        end else if (terms < 97) begin
          send_sum($urandom_range(7, 40), 1'b0);
        end else begin
          send_sum($urandom_range(100, 250), 1'($urandom_range(0, 1)));
        end
      end else if (pick < 85) begin
        terms = $urandom_range(1, 4);
        for (int unsigned i = 0; i < terms; i++) begin
          send_term(rand_operand(), rand_operand(), 32'($urandom), 32'($urandom),
                    1'b0, i == terms - 1);
        end
      end else begin
        send_term(16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Output side: ready drops in bursts at the current idle level.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result beat is matched against the oldest predicted output. Values
  // read here are the ones present just before the edge that moved the beat.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && out_valid && out_ready) begin
      if (requant_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result));
      end else begin
        want = requant_results.pop_front();
        if (result !== want) begin
          report_mismatch($sformatf("result %0d, expected %0d", result, want));
        end
      end
    end
  end

  // Hang detection: any cycle that moves a beat on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 30;
    test_extremes();
    test_rounding();
    test_multi_term();
    test_no_first_term();
    test_relu();
    test_random();
    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
